### rtl/core/rbas_pkg.sv
package rbas_pkg;

    localparam int MAP_W   = 16;
    localparam int REG_W   = 4;
    localparam int CNT_W   = 5;
    localparam int SPILL_W = 8;
    localparam int SPILL_MAX = 255;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2
    } mode_t;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_STACK = 2'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_BAD_KIND  = 3'd2,
        ST_BAD_DEPTH = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [REG_W-1:0]   reg_num;
        logic               pick_any;
        logic               alloc_empty;
        logic [1:0]         alloc_kind;
        logic [SPILL_W-1:0] alloc_depth;
        logic [CNT_W-1:0]   expect_allocated;
        logic [SPILL_W-1:0] expect_spilled;
    } item_t;

    typedef struct packed {
        logic [MAP_W-1:0]   alloc_map;
        logic [CNT_W-1:0]   alloc_count;
        logic [SPILL_W-1:0] spill_count;
        logic [SPILL_W-1:0] spill_level;
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [REG_W-1:0]   granted_reg;
        logic               push_emit;
        logic [SPILL_W-1:0] granted_depth;
        logic               pop_emit;
        state_t             after;
    } result_t;

endpackage

### rtl/core/register_bitmap_allocator_with_spill_unit.sv
// register bitmap allocator with stack spill
// input channel (in_valid/in_ready) takes one request word: allocate, free or
// count check. output channel (out_valid/out_ready) returns one result word per
// request, in order, with the bitmap and counts as they stand after it.
// cfg_valid/cfg_ready/cfg_data writes the reserved-register mask; cfg_ready is
// always high. The user makes writes only while no request is in flight;
// the block does not enforce this. An accepted word waits in the request
// register until the result register is free, then its result moves there.
// throughput: one word per cycle while out_ready is high; the request
// register, the single pass of search and update logic and the result
// register set this, with the bitmap and counters updated as the word moves
// into the result register. When out_ready is low the result holds and the
// request register fills, then in_ready drops until the result is taken.
// reset: both registers empty, bitmap and counts zero, reserved mask 0x0030
// (registers 4 and 5).
module register_bitmap_allocator_with_spill_unit #(
    parameter int NUM_REGS        = 16,
    parameter int MAX_SPILL_DEPTH = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [3:0]  reg_num,
    input  logic        pick_any,
    input  logic        alloc_empty,
    input  logic [1:0]  alloc_kind,
    input  logic [7:0]  alloc_depth,
    input  logic [4:0]  expect_allocated,
    input  logic [7:0]  expect_spilled,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  granted_reg,
    output logic        push_emit,
    output logic [7:0]  granted_depth,
    output logic        pop_emit,
    output logic [15:0] map_now,
    output logic [4:0]  allocated_now,
    output logic [7:0]  spilled_now
);
    import rbas_pkg::*;

    localparam int REG_LIMIT   = (NUM_REGS < MAP_W) ? NUM_REGS : MAP_W;
    localparam int DEPTH_LIMIT = (MAX_SPILL_DEPTH < SPILL_MAX) ? MAX_SPILL_DEPTH : SPILL_MAX;
    localparam logic [MAP_W:0]     LIMIT_ONES  = (MAP_W + 1)'((1 << REG_LIMIT) - 1);
    localparam logic [MAP_W-1:0]   SEARCH_MASK = LIMIT_ONES[MAP_W-1:0] & ~MAP_W'(1);
    localparam logic [CNT_W-1:0]   REG_LIMIT_C   = CNT_W'(REG_LIMIT);
    localparam logic [SPILL_W-1:0] DEPTH_LIMIT_C = SPILL_W'(DEPTH_LIMIT);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [MAP_W-1:0] reserved_reg;
    item_t            item_reg;
    item_t            item_in;
    state_t           state_reg;
    result_t          result_reg;
    result_t          result_next;
    logic             in_fire;
    logic             advance;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        item_in.mode             = mode;
        item_in.reg_num          = reg_num;
        item_in.pick_any         = pick_any;
        item_in.alloc_empty      = alloc_empty;
        item_in.alloc_kind       = alloc_kind;
        item_in.alloc_depth      = alloc_depth;
        item_in.expect_allocated = expect_allocated;
        item_in.expect_spilled   = expect_spilled;
    end

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rbas_step u_step (
        .item        (item_reg),
        .st          (state_reg),
        .reserved    (reserved_reg),
        .search_mask (SEARCH_MASK),
        .reg_limit   (REG_LIMIT_C),
        .depth_limit (DEPTH_LIMIT_C),
        .res         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            reserved_reg    <= 16'h0030;
            state_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                reserved_reg <= cfg_data;
            end
            if (advance)
            begin
                state_reg <= result_next.after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign granted_reg   = result_reg.granted_reg;
    assign push_emit     = result_reg.push_emit;
    assign granted_depth = result_reg.granted_depth;
    assign pop_emit      = result_reg.pop_emit;
    assign map_now       = result_reg.after.alloc_map;
    assign allocated_now = result_reg.after.alloc_count;
    assign spilled_now   = result_reg.after.spill_count;

    // a count only rises when a map bit is set, so it never passes the map
    a_count_le_map: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.alloc_count <= CNT_W'($countones(state_reg.alloc_map)))
        else $error("allocated count above map population");

    // pushes and pops move the stack depth and the spilled count together
    a_spill_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.spill_level == state_reg.spill_count)
        else $error("spill depth and spilled count apart");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.push_emit && result_reg.pop_emit))
        else $error("push and pop in one result");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("allocator state changed without a word moving");

endmodule

### rtl/core/rbas_pick.sv
module rbas_pick (
    input  logic [rbas_pkg::MAP_W-1:0] alloc_map,
    input  logic [rbas_pkg::MAP_W-1:0] reserved,
    input  logic [rbas_pkg::MAP_W-1:0] search_mask,
    output logic                       found,
    output logic [rbas_pkg::REG_W-1:0] pick_reg
);
    import rbas_pkg::*;

    localparam int NIBBLES = MAP_W / 4;

    logic [MAP_W-1:0]   cand;
    logic [NIBBLES-1:0] nib_any;
    logic [1:0]         nib_pos [NIBBLES];

    function automatic logic [1:0] top_bit4(input logic [3:0] v);
        logic [1:0] pos;
        if (v[3])
        begin
            pos = 2'd3;
        end
        else if (v[2])
        begin
            pos = 2'd2;
        end
        else if (v[1])
        begin
            pos = 2'd1;
        end
        else
        begin
            pos = 2'd0;
        end
        return pos;
    endfunction

    // free, not reserved, within the searchable range (never register 0)
    assign cand = ~alloc_map & ~reserved & search_mask;

    always_comb
    begin
        for (int n = 0; n < NIBBLES; n++)
        begin
            nib_any[n] = |cand[4*n +: 4];
            nib_pos[n] = top_bit4(cand[4*n +: 4]);
        end
    end

    always_comb
    begin
        found = |cand;
        priority if (nib_any[3])
        begin
            pick_reg = {2'd3, nib_pos[3]};
        end
        else if (nib_any[2])
        begin
            pick_reg = {2'd2, nib_pos[2]};
        end
        else if (nib_any[1])
        begin
            pick_reg = {2'd1, nib_pos[1]};
        end
        else
        begin
            pick_reg = {2'd0, nib_pos[0]};
        end
    end

endmodule

### rtl/core/rbas_step.sv
module rbas_step (
    input  rbas_pkg::item_t              item,
    input  rbas_pkg::state_t             st,
    input  logic [rbas_pkg::MAP_W-1:0]   reserved,
    input  logic [rbas_pkg::MAP_W-1:0]   search_mask,
    input  logic [rbas_pkg::CNT_W-1:0]   reg_limit,
    input  logic [rbas_pkg::SPILL_W-1:0] depth_limit,
    output rbas_pkg::result_t            res
);
    import rbas_pkg::*;

    logic             pick_found;
    logic [REG_W-1:0] pick_reg;
    logic             found;
    logic [REG_W-1:0] sel;
    state_t           nxt;

    rbas_pick u_pick (
        .alloc_map   (st.alloc_map),
        .reserved    (reserved),
        .search_mask (search_mask),
        .found       (pick_found),
        .pick_reg    (pick_reg)
    );

    always_comb
    begin
        found = item.pick_any ? pick_found : ({1'b0, item.reg_num} < reg_limit);
        sel   = item.pick_any ? pick_reg : item.reg_num;
    end

    always_comb
    begin
        nxt               = st;
        res.status        = ST_OK;
        res.granted_reg   = '0;
        res.push_emit     = 1'b0;
        res.granted_depth = '0;
        res.pop_emit      = 1'b0;
        unique case (item.mode)
            MODE_ALLOC:
            begin
                if (!found)
                begin
                    res.status = ST_NO_FREE;
                end
                else if (st.alloc_map[sel])
                begin
                    // taken: spill to the stack unless it is full
                    if (st.spill_level >= depth_limit || st.spill_count == {SPILL_W{1'b1}})
                    begin
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        nxt.spill_level   = st.spill_level + 1'b1;
                        nxt.spill_count   = st.spill_count + 1'b1;
                        res.granted_reg   = sel;
                        res.push_emit     = 1'b1;
                        res.granted_depth = st.spill_level + 1'b1;
                    end
                end
                else
                begin
                    nxt.alloc_map = st.alloc_map | (MAP_W'(1) << sel);
                    if (st.alloc_count != {CNT_W{1'b1}})
                    begin
                        nxt.alloc_count = st.alloc_count + 1'b1;
                    end
                    res.granted_reg = sel;
                end
            end
            MODE_FREE:
            begin
                if (item.alloc_empty)
                begin
                    nxt = st;
                end
                else if (item.alloc_kind != KIND_PLAIN && item.alloc_kind != KIND_STACK)
                begin
                    res.status = ST_BAD_KIND;
                end
                else if (item.alloc_kind == KIND_STACK)
                begin
                    if (item.alloc_depth != st.spill_level)
                    begin
                        res.status = ST_BAD_DEPTH;
                    end
                    else
                    begin
                        res.pop_emit = 1'b1;
                        if (st.spill_count != '0)
                        begin
                            nxt.spill_count = st.spill_count - 1'b1;
                        end
                        if (st.spill_level != '0)
                        begin
                            nxt.spill_level = st.spill_level - 1'b1;
                        end
                    end
                end
                else
                begin
                    nxt.alloc_map = st.alloc_map & ~(MAP_W'(1) << item.reg_num);
                    if (st.alloc_count != '0)
                    begin
                        nxt.alloc_count = st.alloc_count - 1'b1;
                    end
                end
            end
            MODE_CHECK:
            begin
                if (st.alloc_count != item.expect_allocated
                    || st.spill_count != item.expect_spilled)
                begin
                    res.status = ST_MISMATCH;
                end
            end
            default:
            begin
                nxt = st;
            end
        endcase
        res.after = nxt;
    end

endmodule
